>>> hw/rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;
    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sha256_stream_hash_top.sv
// channel  | signals                                   | role
// input    | valid ready data_byte byte_present message_end | one message byte word
// output   | valid ready digest_word word_index final_word  | digest words, 8 per message
// A byte word is taken on each valid/ready handshake. Every 64th byte starts a
// block compression (buffer load, 64 rounds, feedforward).
// A message end pads the buffer up to byte 63 one byte per cycle and compresses
// one or two blocks that way, then delivers 8 digest words.
// Memory: 64x8 block buffer; the 16-word schedule window is a shift register.
// Reset loads the initial hash; buffer contents need no clearing.
// ready stays low while padding, while a block is compressed or the digest is delivered.
`default_nettype none
module sha256_stream_hash_top
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid_in,
    output logic             ready_in,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        message_end,
    output logic             valid_out,
    input  wire logic        ready_out,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             final_word
);
    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic        ending_reg;
    logic        lenblk_reg;
    logic        mark_reg;
    logic [6:0]  step_reg;
    logic [2:0]  oidx_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];

    logic [7:0]  buf_mem [64];
    logic [7:0]  buf_rd_reg;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic        buf_we;
    logic [5:0]  buf_ra;

    logic        acc_in;
    assign ready_in  = (state_reg == S_FILL);
    assign acc_in    = valid_in && ready_in;
    assign valid_out = (state_reg == S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign final_word  = (oidx_reg == 3'd7);

    logic [63:0] bits;
    assign bits = {count_reg, 3'b000};

    // padding byte for position fill_reg
    logic [7:0] pad_byte;
    always_comb
    begin
        if (fill_reg >= LEN_POS && lenblk_reg)
            pad_byte = bits[8'd63 - {2'b00, fill_reg[2:0], 3'b000} -: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        buf_we = 1'b0;
        buf_wa = fill_reg;
        buf_wd = data_byte;
        if (state_reg == S_FILL && acc_in && byte_present)
            buf_we = 1'b1;
        else if (state_reg == S_FILL && acc_in && message_end)
        begin
            buf_we = 1'b1;
            buf_wd = PAD_MARK;
        end
        else if (state_reg == S_PAD)
        begin
            buf_we = 1'b1;
            buf_wd = mark_reg ? PAD_MARK : pad_byte;
        end
    end
    assign buf_ra = step_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa] <= buf_wd;
        buf_rd_reg <= buf_mem[buf_ra];
    end

    // load phase: step 0..64, byte read issued at step s, used at s+1
    word_t load_word;
    assign load_word = {w_reg[15][23:0], buf_rd_reg};

    word_t x15, x2, sg0, sg1, wt, big1, ch, big0, maj, t1, t2;
    always_comb
    begin
        x15  = w_reg[1];
        x2   = w_reg[14];
        sg0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        sg1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wt   = (step_reg < 7'd16) ? w_reg[0] : w_reg[0] + sg0 + w_reg[9] + sg1;
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + round_k(step_reg[5:0]) + wt;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            fill_reg   <= '0;
            count_reg  <= '0;
            ending_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            mark_reg   <= 1'b0;
            step_reg   <= '0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else
        begin
            unique case (state_reg)
                S_FILL:
                begin
                    if (acc_in)
                    begin
                        step_reg <= '0;
                        if (byte_present)
                        begin
                            count_reg <= count_reg + 61'd1;
                            fill_reg  <= fill_reg + 6'd1;
                            ending_reg <= message_end;
                            mark_reg   <= message_end;
                            if (fill_reg == 6'd63)
                                state_reg <= S_LOAD;
                            else if (message_end)
                                state_reg <= S_PAD;
                        end
                        else if (message_end)
                        begin
                            ending_reg <= 1'b1;
                            fill_reg   <= fill_reg + 6'd1;
                            lenblk_reg <= (fill_reg < LEN_POS);
                            if (fill_reg == 6'd63)
                                state_reg <= S_LOAD;
                            else
                                state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // mark still owed after a byte on the end word
                    if (mark_reg)
                    begin
                        mark_reg   <= 1'b0;
                        lenblk_reg <= (fill_reg < LEN_POS);
                    end
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (step_reg != 7'd0)
                    begin
                        if (step_reg[1:0] == 2'd1)
                            for (int i = 0; i < 15; i++)
                                w_reg[i] <= w_reg[i + 1];
                        w_reg[15] <= load_word;
                    end
                    if (step_reg == 7'd64)
                    begin
                        step_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                        state_reg <= S_RND;
                    end
                    else
                        step_reg <= step_reg + 7'd1;
                end
                S_RND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= wt;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    fill_reg <= '0;
                    step_reg <= '0;
                    if (!ending_reg)
                        state_reg <= S_FILL;
                    else if (!lenblk_reg)
                    begin
                        lenblk_reg <= 1'b1;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        oidx_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (ready_out)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_h(3'(i));
                            fill_reg   <= '0;
                            count_reg  <= '0;
                            ending_reg <= 1'b0;
                            lenblk_reg <= 1'b0;
                            state_reg  <= S_FILL;
                        end
                    end
                end
                default: state_reg <= S_FILL;
            endcase
        end
    end
endmodule
`default_nettype wire
